FILE: design/lrk_pkg.sv
// ----------------------------------------------------------------------------
// lrk_pkg
// shared command, status and state codes of the lru-k frame replacer
// ----------------------------------------------------------------------------
package lrk_pkg;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_SET_EVICT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_EVICT = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_META,
    S_TRIM,
    S_WRITE,
    S_SCAN,
    S_SCAN_WAIT,
    S_SCAN_CMP,
    S_DROP,
    S_RESP
  } state_e;

  localparam int unsigned CfgW = 4;
  localparam int unsigned KReset = 2;

endpackage

FILE: design/lru_k_frame_replacer_top.sv
// ----------------------------------------------------------------------------
// lru_k_frame_replacer_top
// lru-k replacement table: per-frame stamp history and victim selection
// ----------------------------------------------------------------------------
// usage: a command transaction is taken when start is high and busy low.
// cmd_i selects record access, set evictable, remove or evict; frame_id_i and
// evictable_flag_i go with it. exactly one result follows per command, shown
// for one cycle with done_o high: status_o, victim_frame_o, evictable_count_o.
// the receiver cannot stall, so results are never held back.
// k_history is written through cfg_valid_i/cfg_ready_o/cfg_data_i while idle
// and no command is offered.
// after acceptance, set evictable and remove go from the metadata step straight
// to the result; record reads the metadata, trims the oldest stamps until the
// history is shorter than k, then writes the stamp and metadata; evict sweeps
// the frame metadata memory once, with a metadata read, stamp read and compare
// for each evictable frame, then drops the victim before the result.
// busy stays high from acceptance through the result cycle; the next command
// can be taken once the block has returned to idle.
// reset clears the live/evictable valid bits (flip-flops, one per frame), the
// access clock and the evictable count; k_history returns to 2. the metadata
// and stamp memories need no clearing pass: a frame that is not live reads
// as empty, and stamps are read only after being written.
// ----------------------------------------------------------------------------
module lru_k_frame_replacer_top #(
  parameter int unsigned FRAME_CNT = 64,
  parameter int unsigned MAX_K = 8,
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               cmd_i,
  input  logic [5:0]               frame_id_i,
  input  logic                     evictable_flag_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lrk_pkg::CfgW-1:0] cfg_data_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic [5:0]               victim_frame_o,
  output logic [6:0]               evictable_count_o
);

  localparam int unsigned FW = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;
  localparam int unsigned HW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned AW = FW + HW;
  localparam int unsigned CNTW = $clog2(FRAME_CNT + 1);
  localparam int unsigned SlotN = 1 << HW;
  localparam logic [STAMP_BITS-1:0] StampMax = '1;
  localparam logic [CW-1:0] MaxKC = CW'(MAX_K);

  typedef struct packed {
    logic [CW-1:0] cnt;
    logic [HW-1:0] head;
  } meta_t;

  // metadata memory and stamp memory
  meta_t meta_mem [FRAME_CNT];
  logic [STAMP_BITS-1:0] stamp_mem [FRAME_CNT*SlotN];
  logic [FRAME_CNT-1:0] live_q, evict_q, live_d, evict_d;

  meta_t meta_rd_q;
  logic meta_we;
  logic [FW-1:0] meta_wa, meta_ra;
  meta_t meta_wd;
  logic [STAMP_BITS-1:0] stamp_rd_q;
  logic stamp_we;
  logic [AW-1:0] stamp_wa, stamp_ra;

  lrk_pkg::state_e state_q, state_d;
  logic [lrk_pkg::CfgW-1:0] k_q;
  logic [STAMP_BITS-1:0] clock_q, clock_d;
  logic [CNTW-1:0] total_q, total_d;
  logic [1:0] cmd_q;
  logic [FW-1:0] fid_q, fid_d;
  logic flag_q, oor_q;
  meta_t cur_q, cur_d;
  logic [FW-1:0] scan_q, scan_d;
  logic found_q, found_d, bshort_q, bshort_d, cshort_q, cshort_d;
  logic [STAMP_BITS-1:0] bstamp_q, bstamp_d;
  logic [FW-1:0] best_q, best_d;
  logic [1:0] status_q, status_d;
  logic [FW-1:0] victim_q, victim_d;

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_wa] <= meta_wd;
    end
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[stamp_wa] <= clock_q;
    end
    stamp_rd_q <= stamp_mem[stamp_ra];
  end

  logic [CW-1:0] keff;
  always_comb begin
    if (k_q == '0) begin
      keff = CW'(1);
    end else if (32'(k_q) > 32'(MAX_K)) begin
      keff = MaxKC;
    end else begin
      keff = CW'(k_q);
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_q != lrk_pkg::S_IDLE);
  assign cfg_ready_o = (state_q == lrk_pkg::S_IDLE) && !start;

  logic fid_oor;
  assign fid_oor = ({26'd0, frame_id_i} >= 32'(FRAME_CNT));

  logic last_frame;
  assign last_frame = ({{(32-FW){1'b0}}, scan_q} == 32'(FRAME_CNT - 1));

  // ring slot helper
  function automatic logic [HW-1:0] ring_add(input logic [HW-1:0] a, input logic [CW-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(MAX_K)) s = s - SW'(MAX_K);
    ring_add = s[HW-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrk_pkg::S_IDLE: begin
        if (accept) begin
          state_d = (lrk_pkg::cmd_e'(cmd_i) == lrk_pkg::CMD_EVICT) ?
                    lrk_pkg::S_SCAN : lrk_pkg::S_META;
        end
      end
      lrk_pkg::S_META: begin
        state_d = (lrk_pkg::cmd_e'(cmd_q) == lrk_pkg::CMD_RECORD && !oor_q) ?
                  lrk_pkg::S_TRIM : lrk_pkg::S_RESP;
      end
      lrk_pkg::S_TRIM: begin
        if (cur_d.cnt < keff) state_d = lrk_pkg::S_WRITE;
      end
      lrk_pkg::S_WRITE: state_d = lrk_pkg::S_RESP;
      lrk_pkg::S_SCAN: begin
        if (live_q[scan_q] && evict_q[scan_q]) begin
          state_d = lrk_pkg::S_SCAN_WAIT;
        end else if (last_frame) begin
          state_d = lrk_pkg::S_DROP;
        end
      end
      lrk_pkg::S_SCAN_WAIT: state_d = lrk_pkg::S_SCAN_CMP;
      lrk_pkg::S_SCAN_CMP: state_d = last_frame ? lrk_pkg::S_DROP : lrk_pkg::S_SCAN;
      lrk_pkg::S_DROP: state_d = lrk_pkg::S_RESP;
      lrk_pkg::S_RESP: state_d = lrk_pkg::S_IDLE;
      default: state_d = lrk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    logic [CW-1:0] off;
    live_d = live_q;
    evict_d = evict_q;
    clock_d = clock_q;
    total_d = total_q;
    fid_d = fid_q;
    cur_d = cur_q;
    scan_d = scan_q;
    found_d = found_q;
    bshort_d = bshort_q;
    cshort_d = cshort_q;
    bstamp_d = bstamp_q;
    best_d = best_q;
    status_d = status_q;
    victim_d = victim_q;
    meta_we = 1'b0;
    meta_wa = fid_q;
    meta_wd = cur_q;
    meta_ra = fid_q;
    stamp_we = 1'b0;
    stamp_wa = {fid_q, ring_add(cur_q.head, cur_q.cnt)};
    stamp_ra = '0;
    off = '0;
    unique case (state_q)
      lrk_pkg::S_IDLE: begin
        fid_d = FW'(frame_id_i);
        meta_ra = FW'(frame_id_i);
        scan_d = '0;
        found_d = 1'b0;
        bshort_d = 1'b0;
        bstamp_d = '0;
        best_d = '0;
        status_d = lrk_pkg::ST_DONE;
        victim_d = '0;
      end
      lrk_pkg::S_META: begin
        if (!oor_q) begin
          unique case (lrk_pkg::cmd_e'(cmd_q))
            lrk_pkg::CMD_RECORD: begin
              if (!live_q[fid_q]) begin
                live_d[fid_q] = 1'b1;
                evict_d[fid_q] = 1'b0;
                cur_d = '0;
              end else begin
                cur_d = meta_rd_q;
              end
            end
            lrk_pkg::CMD_SET_EVICT: begin
              if (live_q[fid_q] && evict_q[fid_q] != flag_q) begin
                evict_d[fid_q] = flag_q;
                total_d = flag_q ? total_q + 1'b1 : total_q - 1'b1;
              end
            end
            lrk_pkg::CMD_REMOVE: begin
              if (live_q[fid_q]) begin
                if (evict_q[fid_q]) begin
                  live_d[fid_q] = 1'b0;
                  evict_d[fid_q] = 1'b0;
                  total_d = total_q - 1'b1;
                end else begin
                  status_d = lrk_pkg::ST_REFUSED;
                end
              end
            end
            default: ;
          endcase
        end
      end
      lrk_pkg::S_TRIM: begin
        if (cur_q.cnt >= keff) begin
          cur_d.head = ring_add(cur_q.head, CW'(1));
          cur_d.cnt = cur_q.cnt - 1'b1;
        end
      end
      lrk_pkg::S_WRITE: begin
        stamp_we = 1'b1;
        meta_we = 1'b1;
        meta_wd.cnt = cur_q.cnt + 1'b1;
        meta_wd.head = cur_q.head;
        if (clock_q != StampMax) clock_d = clock_q + 1'b1;
      end
      lrk_pkg::S_SCAN: begin
        meta_ra = scan_q;
        if (!(live_q[scan_q] && evict_q[scan_q]) && !last_frame) begin
          scan_d = scan_q + 1'b1;
        end
      end
      lrk_pkg::S_SCAN_WAIT: begin
        off = (meta_rd_q.cnt >= keff) ? meta_rd_q.cnt - keff : '0;
        stamp_ra = {scan_q, ring_add(meta_rd_q.head, off)};
        cshort_d = meta_rd_q.cnt < keff;
      end
      lrk_pkg::S_SCAN_CMP: begin
        if (!found_q || (cshort_q && !bshort_q) ||
            (cshort_q == bshort_q && stamp_rd_q < bstamp_q)) begin
          found_d = 1'b1;
          bshort_d = cshort_q;
          bstamp_d = stamp_rd_q;
          best_d = scan_q;
        end
        if (!last_frame) scan_d = scan_q + 1'b1;
      end
      lrk_pkg::S_DROP: begin
        if (found_q) begin
          live_d[best_q] = 1'b0;
          evict_d[best_q] = 1'b0;
          total_d = total_q - 1'b1;
          victim_d = best_q;
        end else begin
          status_d = lrk_pkg::ST_NONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrk_pkg::S_IDLE;
      k_q <= lrk_pkg::CfgW'(lrk_pkg::KReset);
      live_q <= '0;
      evict_q <= '0;
      clock_q <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) k_q <= cfg_data_i;
      live_q <= live_d;
      evict_q <= evict_d;
      clock_q <= clock_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      flag_q <= evictable_flag_i;
      oor_q <= fid_oor;
    end
    fid_q <= fid_d;
    cur_q <= cur_d;
    scan_q <= scan_d;
    found_q <= found_d;
    bshort_q <= bshort_d;
    cshort_q <= cshort_d;
    bstamp_q <= bstamp_d;
    best_q <= best_d;
    status_q <= status_d;
    victim_q <= victim_d;
  end

  assign done_o = (state_q == lrk_pkg::S_RESP);
  assign status_o = status_q;
  assign victim_frame_o = 6'(victim_q);
  assign evictable_count_o = 7'(total_q);

endmodule
